// ----- hdl/rar_pkg.sv -----
// rar_pkg: shared constants, codes and types of the recall-at-R accumulator.
// Used by rar_cell, rar_chain and recall_at_r_accumulator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

    localparam int MAX_TRUTH  = 256;
    localparam int TRUTH_AW   = $clog2(MAX_TRUTH);
    localparam int TC_W       = $clog2(MAX_TRUTH + 1);
    localparam int MAX_CAND   = 1024;
    localparam int CAND_AW    = $clog2(MAX_CAND);
    localparam int POS_W      = $clog2(MAX_CAND + 1);
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = 2;
    localparam int INDEX_BITS = 24;
    localparam int CNT_W      = 32;
    localparam int TOPK_W     = 9;
    localparam int CFG_IW     = 2;
    localparam int ROW_W      = NUM_SLOTS * CNT_W;

    localparam logic [TOPK_W-1:0] TOPK_RESET [NUM_SLOTS] = '{9'd1, 9'd10, 9'd100, 9'd0};

    typedef enum logic [1:0] {
        OP_LOAD_TRUTH = 2'd0,
        OP_CANDIDATE  = 2'd1,
        OP_READ_SUM   = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_TRUTH_FULL = 2'd1,
        STATUS_BEYOND     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_EMIT
    } state_t;

    // Search token moving down the cell chain
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [TRUTH_AW-1:0] pos;
    } token_t;

endpackage

`default_nettype wire

// ----- hdl/rar_cell.sv -----
// rar_cell: one ground-truth entry plus one stage of the search token.
// Depends on rar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rar_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [rar_pkg::INDEX_BITS-1:0]     wr_data,
    input  wire logic [rar_pkg::INDEX_BITS-1:0]     cand_idx,
    input  wire logic [rar_pkg::TC_W-1:0]           truth_count,
    input  wire logic [rar_pkg::TRUTH_AW-1:0]       cell_pos,
    input  wire rar_pkg::token_t                    tok_in,
    output rar_pkg::token_t                         tok_out
);

    logic [rar_pkg::INDEX_BITS-1:0] entry_reg;
    rar_pkg::token_t                tok_reg;
    rar_pkg::token_t                tok_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    // Keep the first match; only entries below the fill level take part
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && ({1'b0, cell_pos} < truth_count)
            && (entry_reg == cand_idx))
        begin
            tok_next.found = 1'b1;
            tok_next.pos   = cell_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ----- hdl/rar_chain.sv -----
// rar_chain: row of rar_cell instances holding the ground truth in rank order.
// Depends on rar_pkg and rar_cell.
`timescale 1ns / 1ps
`default_nettype none

module rar_chain (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [rar_pkg::TRUTH_AW-1:0]       wr_addr,
    input  wire logic [rar_pkg::INDEX_BITS-1:0]     wr_data,
    input  wire logic [rar_pkg::INDEX_BITS-1:0]     cand_idx,
    input  wire logic [rar_pkg::TC_W-1:0]           truth_count,
    input  wire logic                               start,
    output rar_pkg::token_t                         tok_out
);

    rar_pkg::token_t tok [rar_pkg::MAX_TRUTH + 1];

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start;
    end

    for (genvar i = 0; i < rar_pkg::MAX_TRUTH; i++)
    begin : g_cell
        rar_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_en && (wr_addr == rar_pkg::TRUTH_AW'(i))),
            .wr_data     (wr_data),
            .cand_idx    (cand_idx),
            .truth_count (truth_count),
            .cell_pos    (rar_pkg::TRUTH_AW'(i)),
            .tok_in      (tok[i]),
            .tok_out     (tok[i+1])
        );
    end

    assign tok_out = tok[rar_pkg::MAX_TRUTH];

endmodule

`default_nettype wire

// ----- hdl/recall_at_r_accumulator.sv -----
// recall_at_r_accumulator: top level of the recall-at-R hit counter.
// Depends on rar_pkg and rar_chain (which instantiates rar_cell).
//
//   channel   handshake              payload
//   --------  ---------------------  ----------------------------------------------
//   input     in_valid / in_stall    operation item_index last_of_query
//                                    slot_select read_position
//   output    out_valid / out_stall  cumulative_hits queries_seen status
//   config    cfg_valid / cfg_ready  cfg_index cfg_data (cfg_ready always high)
//
// One input transaction at a time. Load truth: IDLE, then EMIT. Read sum: IDLE, READ, EMIT.
// Candidate: IDLE, SEARCH while the token walks the 256-cell chain, then EMIT (past the store end: IDLE, EMIT).
// Clear: IDLE, EMIT, then a sweep over all MAX_CAND (1024) counter rows, zeroing one counter row per
// cycle; the same sweep runs after reset. in_stall is high throughout a sweep.
// A result waiting under out_stall holds the next result, not the next input transaction.
`timescale 1ns / 1ps
`default_nettype none

module recall_at_r_accumulator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         operation,
    input  wire logic [rar_pkg::INDEX_BITS-1:0]     item_index,
    input  wire logic                               last_of_query,
    input  wire logic [rar_pkg::SLOT_W-1:0]         slot_select,
    input  wire logic [rar_pkg::CAND_AW-1:0]        read_position,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [rar_pkg::CNT_W-1:0]               cumulative_hits,
    output logic [rar_pkg::CNT_W-1:0]               queries_seen,
    output logic [1:0]                              status,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rar_pkg::CFG_IW-1:0]         cfg_index,
    input  wire logic [rar_pkg::TOPK_W-1:0]         cfg_data
);

    rar_pkg::state_t                state_reg, state_next;
    rar_pkg::op_t                   op;
    rar_pkg::token_t                chain_out;

    logic [rar_pkg::TOPK_W-1:0]     topk_reg [rar_pkg::NUM_SLOTS];
    logic [rar_pkg::TC_W-1:0]       truth_count_reg;
    logic [rar_pkg::POS_W-1:0]      cand_pos_reg;
    logic [rar_pkg::CNT_W-1:0]      running_sum_reg;
    logic [rar_pkg::CNT_W-1:0]      query_count_reg;
    logic [rar_pkg::CAND_AW-1:0]    sweep_addr_reg;
    logic                           sweep_pending_reg;
    logic [rar_pkg::INDEX_BITS-1:0] cand_idx_reg;
    logic                           last_reg;
    logic                           rpos_zero_reg;
    logic [rar_pkg::SLOT_W-1:0]     slot_reg;
    logic [rar_pkg::CNT_W-1:0]      res_hits_reg;
    rar_pkg::status_t               res_status_reg;

    logic                           out_valid_reg;
    logic [rar_pkg::CNT_W-1:0]      out_hits_reg;
    logic [rar_pkg::CNT_W-1:0]      out_queries_reg;
    rar_pkg::status_t               out_status_reg;

    logic [rar_pkg::ROW_W-1:0]      mem [rar_pkg::MAX_CAND];
    logic [rar_pkg::ROW_W-1:0]      rd_data_reg;
    logic                           mem_we;
    logic [rar_pkg::CAND_AW-1:0]    mem_waddr;
    logic [rar_pkg::ROW_W-1:0]      mem_wdata;
    logic                           mem_re;
    logic [rar_pkg::CAND_AW-1:0]    mem_raddr;
    logic [rar_pkg::ROW_W-1:0]      row_inc;

    logic                           in_accept;
    logic                           out_free;
    logic                           truth_room;
    logic                           cand_room;
    logic [rar_pkg::CNT_W-1:0]      read_field;
    logic [rar_pkg::CNT_W-1:0]      read_base;
    logic [rar_pkg::CNT_W:0]        read_wide;
    logic [rar_pkg::CNT_W-1:0]      read_sum;
    logic [rar_pkg::CNT_W-1:0]      query_count_inc;

    assign op         = rar_pkg::op_t'(operation);
    assign in_stall   = (state_reg != rar_pkg::S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign truth_room = (truth_count_reg < rar_pkg::TC_W'(rar_pkg::MAX_TRUTH));
    assign cand_room  = (cand_pos_reg < rar_pkg::POS_W'(rar_pkg::MAX_CAND));
    assign cfg_ready  = 1'b1;

    assign query_count_inc = (query_count_reg == '1) ? query_count_reg
                                                     : query_count_reg + 1'b1;

    // The first cell compares at the accept edge, before cand_idx_reg is loaded
    rar_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (in_accept && (op == rar_pkg::OP_LOAD_TRUTH) && truth_room),
        .wr_addr     (truth_count_reg[rar_pkg::TRUTH_AW-1:0]),
        .wr_data     (item_index),
        .cand_idx    (in_stall ? cand_idx_reg : item_index),
        .truth_count (truth_count_reg),
        .start       (in_accept && (op == rar_pkg::OP_CANDIDATE) && cand_room),
        .tok_out     (chain_out)
    );

    // Saturating per-slot increment of the counter row read at accept time
    always_comb
    begin
        for (int s = 0; s < rar_pkg::NUM_SLOTS; s++)
        begin
            row_inc[s*rar_pkg::CNT_W +: rar_pkg::CNT_W] =
                rd_data_reg[s*rar_pkg::CNT_W +: rar_pkg::CNT_W];
            if (chain_out.found && ({1'b0, chain_out.pos} < topk_reg[s])
                && (rd_data_reg[s*rar_pkg::CNT_W +: rar_pkg::CNT_W] != '1))
            begin
                row_inc[s*rar_pkg::CNT_W +: rar_pkg::CNT_W] =
                    rd_data_reg[s*rar_pkg::CNT_W +: rar_pkg::CNT_W] + 1'b1;
            end
        end
    end

    assign read_field = rd_data_reg[slot_reg*rar_pkg::CNT_W +: rar_pkg::CNT_W];
    assign read_base  = rpos_zero_reg ? '0 : running_sum_reg;
    assign read_wide  = {1'b0, read_base} + {1'b0, read_field};
    assign read_sum   = read_wide[rar_pkg::CNT_W] ? '1 : read_wide[rar_pkg::CNT_W-1:0];

    // Memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cand_pos_reg[rar_pkg::CAND_AW-1:0];
        mem_wdata = row_inc;
        if (state_reg == rar_pkg::S_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == rar_pkg::S_SEARCH) && chain_out.valid)
        begin
            mem_we = 1'b1;
        end
        mem_re    = in_accept && ((op == rar_pkg::OP_CANDIDATE) || (op == rar_pkg::OP_READ_SUM));
        mem_raddr = (op == rar_pkg::OP_CANDIDATE) ? cand_pos_reg[rar_pkg::CAND_AW-1:0]
                                                  : read_position;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rar_pkg::S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::S_SWEEP:
            begin
                if (sweep_addr_reg == rar_pkg::CAND_AW'(rar_pkg::MAX_CAND - 1))
                begin
                    state_next = rar_pkg::S_IDLE;
                end
            end
            rar_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (op)
                        rar_pkg::OP_LOAD_TRUTH: state_next = rar_pkg::S_EMIT;
                        rar_pkg::OP_CANDIDATE:
                            state_next = cand_room ? rar_pkg::S_SEARCH : rar_pkg::S_EMIT;
                        rar_pkg::OP_READ_SUM:   state_next = rar_pkg::S_READ;
                        rar_pkg::OP_CLEAR:      state_next = rar_pkg::S_EMIT;
                    endcase
                end
            end
            rar_pkg::S_SEARCH:
            begin
                if (chain_out.valid)
                begin
                    state_next = rar_pkg::S_EMIT;
                end
            end
            rar_pkg::S_READ:
            begin
                state_next = rar_pkg::S_EMIT;
            end
            rar_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = sweep_pending_reg ? rar_pkg::S_SWEEP : rar_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rar_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < rar_pkg::NUM_SLOTS; s++)
            begin
                topk_reg[s] <= rar_pkg::TOPK_RESET[s];
            end
            truth_count_reg   <= '0;
            cand_pos_reg      <= '0;
            running_sum_reg   <= '0;
            query_count_reg   <= '0;
            sweep_addr_reg    <= '0;
            sweep_pending_reg <= 1'b0;
            cand_idx_reg      <= '0;
            last_reg          <= 1'b0;
            rpos_zero_reg     <= 1'b0;
            slot_reg          <= '0;
            res_hits_reg      <= '0;
            res_status_reg    <= rar_pkg::STATUS_OK;
            out_valid_reg     <= 1'b0;
            out_hits_reg      <= '0;
            out_queries_reg   <= '0;
            out_status_reg    <= rar_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                topk_reg[cfg_index] <= cfg_data;
            end

            // Drop the taken result unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != rar_pkg::S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                rar_pkg::S_SWEEP:
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
                rar_pkg::S_IDLE:
                begin
                    if (in_accept)
                    begin
                        res_hits_reg   <= '0;
                        res_status_reg <= rar_pkg::STATUS_OK;
                        unique case (op)
                            rar_pkg::OP_LOAD_TRUTH:
                            begin
                                if (truth_room)
                                begin
                                    truth_count_reg <= truth_count_reg + 1'b1;
                                end
                                else
                                begin
                                    res_status_reg <= rar_pkg::STATUS_TRUTH_FULL;
                                end
                            end
                            rar_pkg::OP_CANDIDATE:
                            begin
                                cand_idx_reg <= item_index;
                                last_reg     <= last_of_query;
                                // Beyond the store: nothing to count; a last flag closes the query now
                                if (!cand_room)
                                begin
                                    res_status_reg <= rar_pkg::STATUS_BEYOND;
                                    if (last_of_query)
                                    begin
                                        query_count_reg <= query_count_inc;
                                        truth_count_reg <= '0;
                                        cand_pos_reg    <= '0;
                                    end
                                end
                            end
                            rar_pkg::OP_READ_SUM:
                            begin
                                // read_position and slot_select never exceed the store
                                rpos_zero_reg <= (read_position == '0);
                                slot_reg      <= slot_select;
                            end
                            rar_pkg::OP_CLEAR:
                            begin
                                running_sum_reg   <= '0;
                                query_count_reg   <= '0;
                                truth_count_reg   <= '0;
                                cand_pos_reg      <= '0;
                                sweep_pending_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                rar_pkg::S_SEARCH:
                begin
                    if (chain_out.valid)
                    begin
                        if (last_reg)
                        begin
                            query_count_reg <= query_count_inc;
                            truth_count_reg <= '0;
                            cand_pos_reg    <= '0;
                        end
                        else
                        begin
                            cand_pos_reg <= cand_pos_reg + 1'b1;
                        end
                    end
                end
                rar_pkg::S_READ:
                begin
                    running_sum_reg <= read_sum;
                    res_hits_reg    <= read_sum;
                end
                rar_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_hits_reg      <= res_hits_reg;
                        out_queries_reg   <= query_count_reg;
                        out_status_reg    <= res_status_reg;
                        sweep_pending_reg <= 1'b0;
                    end
                end
                default:
                begin
                    sweep_pending_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign cumulative_hits = out_hits_reg;
    assign queries_seen    = out_queries_reg;
    assign status          = out_status_reg;

endmodule

`default_nettype wire

// ----- bench/recall_at_r_accumulator_checker.sv -----
// Checker for the recall-at-R accumulator: watches the input, output and config channels,
// predicts each result from its own copy of truth store, hit counters and top-k settings.
// Depends on rar_pkg for the operation and status codes and the store sizes.
`timescale 1ns / 1ps

module recall_at_r_accumulator_checker
    import rar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [INDEX_BITS-1:0] item_index,
    input  logic                  last_of_query,
    input  logic [SLOT_W-1:0]     slot_select,
    input  logic [CAND_AW-1:0]    read_position,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CNT_W-1:0]      cumulative_hits,
    input  logic [CNT_W-1:0]      queries_seen,
    input  logic [1:0]            status,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [TOPK_W-1:0]     cfg_data,
    output int                    pending,
    output int                    mismatches,
    output int                    checked
);

    typedef struct packed {
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] queries;
        status_t          st;
    } recall_report_t;

    recall_report_t        recall_reports[$];

    logic [TOPK_W-1:0]     topk_reg [NUM_SLOTS];
    logic [INDEX_BITS-1:0] truth_mem [MAX_TRUTH];
    int unsigned           truth_cnt;
    int unsigned           cand_pos;
    logic [CNT_W-1:0]      hit_mem [NUM_SLOTS*MAX_CAND];
    logic [CNT_W-1:0]      prefix_sum;
    logic [CNT_W-1:0]      query_total;
    int                    fail_cnt;
    int                    done_cnt;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic void clear_counts();
        for (int a = 0; a < NUM_SLOTS * MAX_CAND; a++)
            hit_mem[a] = '0;
        prefix_sum  = '0;
        query_total = '0;
        truth_cnt   = 0;
        cand_pos    = 0;
    endfunction

    // Update the model state for one input transaction and return its result.
    function automatic recall_report_t advance_recall(op_t op, logic [INDEX_BITS-1:0] idx,
                                                      logic last, logic [SLOT_W-1:0] slot,
                                                      logic [CAND_AW-1:0] rpos);
        recall_report_t rep;
        int unsigned    k;
        bit             found;
        int             a;
        rep.hits = '0;
        rep.st   = STATUS_OK;
        case (op)
            OP_LOAD_TRUTH:
            begin
                if (truth_cnt < MAX_TRUTH)
                begin
                    truth_mem[truth_cnt] = idx;
                    truth_cnt++;
                end
                else
                    rep.st = STATUS_TRUTH_FULL;
            end
            OP_CANDIDATE:
            begin
                if (cand_pos < MAX_CAND)
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        k = topk_reg[s];
                        // only the stored part of the truth list takes part
                        if (k > truth_cnt)
                            k = truth_cnt;
                        found = 1'b0;
                        for (int i = 0; i < k; i++)
                            if (truth_mem[i] == idx)
                                found = 1'b1;
                        if (found)
                        begin
                            a = s * MAX_CAND + cand_pos;
                            hit_mem[a] = sat_add(hit_mem[a], 1);
                        end
                    end
                    cand_pos++;
                end
                else
                    rep.st = STATUS_BEYOND;
                if (last)
                begin
                    query_total = sat_add(query_total, 1);
                    truth_cnt   = 0;
                    cand_pos    = 0;
                end
            end
            OP_READ_SUM:
            begin
                if (rpos == 0)
                    prefix_sum = '0;
                if (rpos < MAX_CAND)
                begin
                    if (slot < NUM_SLOTS)
                        prefix_sum = sat_add(prefix_sum, hit_mem[slot * MAX_CAND + rpos]);
                end
                else
                    rep.st = STATUS_BEYOND;
                rep.hits = prefix_sum;
            end
            default:
                clear_counts();
        endcase
        rep.queries = query_total;
        return rep;
    endfunction

    task automatic check_output();
        recall_report_t want;
        if (recall_reports.size() == 0)
        begin
            $display("%0t: result with nothing expected: hits %0d queries %0d status %0d",
                     $time, cumulative_hits, queries_seen, status);
            fail_cnt++;
        end
        else
        begin
            want = recall_reports.pop_front();
            done_cnt++;
            if (cumulative_hits !== want.hits)
            begin
                $display("%0t: cumulative_hits expected %0d, got %0d",
                         $time, want.hits, cumulative_hits);
                fail_cnt++;
            end
            if (queries_seen !== want.queries)
            begin
                $display("%0t: queries_seen expected %0d, got %0d",
                         $time, want.queries, queries_seen);
                fail_cnt++;
            end
            if (status !== want.st)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.st, status);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topk_reg[0] = 9'd1;
            topk_reg[1] = 9'd10;
            topk_reg[2] = 9'd100;
            topk_reg[3] = 9'd0;
            clear_counts();
            recall_reports.delete();
            fail_cnt   = 0;
            done_cnt   = 0;
            pending    <= 0;
            mismatches <= 0;
            checked    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                topk_reg[cfg_index] = cfg_data;
            if (out_valid && !out_stall)
                check_output();
            if (in_valid && !in_stall)
                recall_reports.push_back(advance_recall(op_t'(operation), item_index,
                                                        last_of_query, slot_select,
                                                        read_position));
            pending    <= recall_reports.size();
            mismatches <= fail_cnt;
            checked    <= done_cnt;
        end
    end

endmodule

// ----- bench/recall_at_r_accumulator_tb.sv -----
// Testbench top for recall_at_r_accumulator: drives queries, reads, clears and top-k writes
// with random idling, and gives the verdict from recall_at_r_accumulator_checker.
// Depends on rar_pkg, the block and the checker.
`timescale 1ns / 1ps

module recall_at_r_accumulator_tb;
    import rar_pkg::*;

    localparam int NUM_ITEMS     = 1350;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES   = 700;
    localparam int TAIL_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 8000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation = OP_LOAD_TRUTH;
    logic [INDEX_BITS-1:0] item_index = '0;
    logic                  last_of_query = 1'b0;
    logic [SLOT_W-1:0]     slot_select = '0;
    logic [CAND_AW-1:0]    read_position = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CNT_W-1:0]      cumulative_hits;
    logic [CNT_W-1:0]      queries_seen;
    logic [1:0]            status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IW-1:0]     cfg_index = '0;
    logic [TOPK_W-1:0]     cfg_data = '0;

    int                    pending;
    int                    mismatches;
    int                    checked;
    int                    n_sent = 0;
    int                    tx_burst = 0;
    int                    rx_burst = 0;
    int                    quiet_cycles = 0;
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    recall_at_r_accumulator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .item_index      (item_index),
        .last_of_query   (last_of_query),
        .slot_select     (slot_select),
        .read_position   (read_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cumulative_hits (cumulative_hits),
        .queries_seen    (queries_seen),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    recall_at_r_accumulator_checker hit_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .item_index      (item_index),
        .last_of_query   (last_of_query),
        .slot_select     (slot_select),
        .read_position   (read_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cumulative_hits (cumulative_hits),
        .queries_seen    (queries_seen),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending         (pending),
        .mismatches      (mismatches),
        .checked         (checked)
    );

    // Idle draws: mostly a random idle gap, with occasional runs of back-to-back transactions.
    function automatic int tx_gap();
        if (tx_burst > 0)
        begin
            tx_burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            tx_burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic int rx_gap();
        if (rx_burst > 0)
        begin
            rx_burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            rx_burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [INDEX_BITS-1:0] rand_index();
        case ($urandom_range(0, 5))
            0:       return INDEX_BITS'($urandom_range(0, 15));
            1:       return {INDEX_BITS{1'b1}} - INDEX_BITS'($urandom_range(0, 15));
            default: return INDEX_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [TOPK_W-1:0] rand_topk();
        case ($urandom_range(0, 4))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'd1;
            3:       return TOPK_W'($urandom_range(2, 16));
            default: return TOPK_W'($urandom_range(0, 256));
        endcase
    endfunction

    // Valid stays high after acceptance; the next call either reuses it or drops it for a gap.
    task automatic send_txn(input op_t op, input logic [INDEX_BITS-1:0] idx, input logic last,
                            input logic [SLOT_W-1:0] slot, input logic [CAND_AW-1:0] rpos);
        int gap;
        gap = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        item_index    <= idx;
        last_of_query <= last;
        slot_select   <= slot;
        read_position <= rpos;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_topk(input logic [TOPK_W-1:0] k0, input logic [TOPK_W-1:0] k1,
                              input logic [TOPK_W-1:0] k2, input logic [TOPK_W-1:0] k3);
        logic [TOPK_W-1:0] vals [NUM_SLOTS];
        vals[0] = k0;
        vals[1] = k1;
        vals[2] = k2;
        vals[3] = k3;
        wait_drained();
        // let a clear sweep run out before touching the registers
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IW'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // One query: truth list then candidates; sometimes the last flag is dropped.
    task automatic run_query(input int n_truth, input int n_cand, inout int issued);
        logic [INDEX_BITS-1:0] truth_q[$];
        logic [INDEX_BITS-1:0] v;
        bit                    end_query;
        end_query = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < n_truth; i++)
        begin
            if (truth_q.size() != 0 && $urandom_range(0, 9) == 0)
                v = truth_q[$urandom_range(0, truth_q.size() - 1)];
            else
                v = rand_index();
            truth_q.push_back(v);
            send_txn(OP_LOAD_TRUTH, v, $urandom_range(0, 7) == 0, SLOT_W'($urandom_range(0, 3)),
                     CAND_AW'($urandom_range(0, 1023)));
            issued++;
        end
        for (int i = 0; i < n_cand; i++)
        begin
            if (truth_q.size() != 0 && $urandom_range(0, 9) < 6)
                v = truth_q[$urandom_range(0, truth_q.size() - 1)];
            else if (truth_q.size() != 0 && $urandom_range(0, 2) == 0)
                v = truth_q[$urandom_range(0, truth_q.size() - 1)]
                    ^ (INDEX_BITS'(1) << $urandom_range(0, INDEX_BITS - 1));
            else
                v = rand_index();
            send_txn(OP_CANDIDATE, v, end_query && (i == n_cand - 1),
                     SLOT_W'($urandom_range(0, 3)), CAND_AW'($urandom_range(0, 1023)));
            issued++;
        end
    endtask

    // Prefix-sum readout, mostly ascending from position zero.
    task automatic run_reads(inout int issued);
        logic [SLOT_W-1:0]  slot;
        logic [CAND_AW-1:0] pos;
        int                 n;
        slot = SLOT_W'($urandom_range(0, 3));
        n    = $urandom_range(1, 12);
        pos  = ($urandom_range(0, 4) == 0) ? CAND_AW'($urandom_range(0, 1023)) : '0;
        for (int i = 0; i < n; i++)
        begin
            send_txn(OP_READ_SUM, rand_index(), $urandom_range(0, 1), slot, pos);
            issued++;
            if ($urandom_range(0, 7) == 0)
                pos = CAND_AW'($urandom_range(0, 1023));
            else
                pos = pos + 1'b1;
        end
    endtask

    task automatic send_noise(inout int issued);
        op_t op;
        if ($urandom_range(0, 11) == 0)
            op = OP_CLEAR;
        else
            op = op_t'($urandom_range(0, 2));
        send_txn(op, rand_index(), $urandom_range(0, 1), SLOT_W'($urandom_range(0, 3)),
                 CAND_AW'($urandom_range(0, 1023)));
        issued++;
    endtask

    // Receiver: random stall per result, plus one long hold-off to back up the block.
    initial
    begin
        int w;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            w = rx_gap();
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("recall_at_r_accumulator_tb failed");
            $finish;
        end
    end

    initial
    begin
        int issued;
        int scratch;
        int r;
        issued  = 0;
        scratch = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset top-k values, field extremes, every operation, ignored last flags.
        send_txn(OP_READ_SUM,   24'h000000, 1'b0, 2'd0, 10'd0);
        send_txn(OP_LOAD_TRUTH, 24'h000000, 1'b1, 2'd3, 10'd1023);
        send_txn(OP_LOAD_TRUTH, 24'hFFFFFF, 1'b0, 2'd0, 10'd0);
        send_txn(OP_LOAD_TRUTH, 24'hAAAAAA, 1'b0, 2'd1, 10'd341);
        send_txn(OP_LOAD_TRUTH, 24'h555555, 1'b0, 2'd2, 10'd682);
        send_txn(OP_CANDIDATE,  24'h000000, 1'b0, 2'd3, 10'd1023);
        send_txn(OP_CANDIDATE,  24'hFFFFFF, 1'b0, 2'd0, 10'd0);
        send_txn(OP_CANDIDATE,  24'h123456, 1'b0, 2'd1, 10'd5);
        send_txn(OP_CANDIDATE,  24'h555555, 1'b1, 2'd2, 10'd9);
        send_txn(OP_READ_SUM,   24'hFFFFFF, 1'b0, 2'd0, 10'd0);
        send_txn(OP_READ_SUM,   24'h000000, 1'b1, 2'd1, 10'd0);
        send_txn(OP_READ_SUM,   24'h000000, 1'b0, 2'd1, 10'd1);
        send_txn(OP_READ_SUM,   24'h000000, 1'b0, 2'd2, 10'd2);
        send_txn(OP_READ_SUM,   24'hFFFFFF, 1'b1, 2'd3, 10'd1023);
        send_txn(OP_CANDIDATE,  24'hFFFFFF, 1'b1, 2'd0, 10'd0);
        send_txn(OP_CLEAR,      24'hFFFFFF, 1'b1, 2'd3, 10'd1023);
        send_txn(OP_READ_SUM,   24'h000000, 1'b0, 2'd2, 10'd0);
        send_txn(OP_LOAD_TRUTH, 24'h800001, 1'b0, 2'd0, 10'd512);
        send_txn(OP_CANDIDATE,  24'h800001, 1'b0, 2'd3, 10'd1023);
        send_txn(OP_CANDIDATE,  24'h000000, 1'b1, 2'd0, 10'd0);
        send_txn(OP_READ_SUM,   24'h000000, 1'b0, 2'd1, 10'd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_topk(9'd256, 9'd1, 9'd0, 9'd256);
                1:       write_topk(9'd0, 9'd0, 9'd0, 9'd0);
                2:       write_topk(9'd2, 9'd256, 9'd17, 9'd5);
                default: write_topk(rand_topk(), rand_topk(), rand_topk(), rand_topk());
            endcase
            if (p == 0)
            begin
                // overfill the truth store while the receiver holds off
                hold_req = 1'b1;
                run_query(MAX_TRUTH + $urandom_range(1, 6), $urandom_range(2, 6), scratch);
                run_reads(scratch);
            end
            if (p == 2)
            begin
                // run candidates past the end of the counter store
                run_query($urandom_range(4, 20), MAX_CAND + $urandom_range(1, 4), scratch);
                for (int i = 0; i < 4; i++)
                    send_txn(OP_READ_SUM, rand_index(), 1'b0, SLOT_W'(i),
                             (i == 0) ? CAND_AW'(0) : CAND_AW'(1020 + i));
            end
            // random traffic tops the running total up to this phase's share
            while (n_sent < (NUM_ITEMS * (p + 1)) / NUM_PHASES)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_noise(issued);
                else if (r <= 6)
                    run_query(($urandom_range(0, 9) == 0) ? 0 :
                              (($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12)),
                              $urandom_range(1, 10), issued);
                else
                    run_reads(issued);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d transactions, %0d results checked, %0d top-k settings",
                 n_sent, checked, NUM_PHASES + 1);
        $display("incl. full truth store, candidates past store end, clears, output hold-off");
        if (mismatches == 0)
            $display("recall_at_r_accumulator_tb passed");
        else
            $display("recall_at_r_accumulator_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rar_pkg.sv
hdl/rar_cell.sv
hdl/rar_chain.sv
hdl/recall_at_r_accumulator.sv
bench/recall_at_r_accumulator_checker.sv
bench/recall_at_r_accumulator_tb.sv
